FILE: rtl/spa_pkg.sv
// Package for the slot pool allocator: request and result types, operation,
// status and state codes, and default sizes.
// No dependencies; the allocator, link store, checker and testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MAX_RESULTS = 16;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_LIST  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_POOL_EMPTY = 2'd1,
		ST_NOT_ACTIVE = 2'd2,
		ST_LIST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_WB,
		S_FREE_HEAD,
		S_FREE_WALK,
		S_FREE_PUSH,
		S_LIST_WALK
	} state_t;

	typedef struct packed {
		op_t        operation;
		logic [3:0] slot;
	} request_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] slot_out;
		logic       last;
	} result_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clear;
	} link_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/slot_pool_free_list_allocator.sv
// Top level of the slot pool allocator: request decode, list-walking state
// machine, head and flag registers, and the result register.
// Depends on spa_pkg and spa_links.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low; each result shows on
// result for one cycle with strobe high, and the receiver must take it then.
// Rejected requests and clear give their result in the cycle after the request;
// allocate reads the free head's link, then answers from its write-back state.
// Free reads the freed slot's link and then walks the active list one link per
// cycle through the link RAM, then answers from its push state. List emits one
// active slot per cycle from its walk state, at most 16.

module slot_pool_free_list_allocator
	import spa_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire request_t request,
	output logic          busy,
	output result_t       result,
	output logic          strobe
);

	localparam int IW         = $clog2(SLOTS);
	localparam int LW         = $clog2(SLOTS + 1);
	localparam int SW         = $clog2(SLOTS + 1);
	localparam int LIST_LIMIT = (SLOTS < MAX_RESULTS) ? SLOTS : MAX_RESULTS;

	state_t         state_q, state_d;
	logic [LW-1:0]  free_head_q, active_head_q;
	logic [SLOTS-1:0] flags_q;
	logic [IW-1:0]  s_q, cur_q;
	logic [LW-1:0]  nxs_q;
	logic [SW-1:0]  step_q;
	result_t        result_q;
	logic           strobe_q;

	link_ctl_t      lk_ctl;
	logic [IW-1:0]  lk_raddr, lk_waddr;
	logic [LW-1:0]  lk_wdata, lk_rdata;

	logic           accept;
	logic [IW+3:0]  slot_w;
	logic [IW-1:0]  slot_idx;
	logic           slot_ok;
	logic           free_null, head_null, head_is_s;
	logic           rd_null, rd_match, walk_more, list_end;
	logic [IW-1:0]  rd_idx;

	logic           emit;
	status_t        emit_st;
	logic [IW-1:0]  emit_slot;
	logic           emit_last;
	logic [IW+3:0]  emit_w;

	spa_links #(
		.SLOTS(SLOTS)
	) u_links (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (lk_ctl),
		.raddr (lk_raddr),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.rdata (lk_rdata)
	);

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign slot_w    = {IW'(0), request.slot};
	assign slot_idx  = slot_w[IW-1:0];
	assign slot_ok   = ({3'b000, request.slot} < 7'(SLOTS)) && flags_q[slot_idx];
	assign free_null = (free_head_q >= LW'(SLOTS));
	assign head_null = (active_head_q >= LW'(SLOTS));
	assign head_is_s = (active_head_q == LW'(s_q));
	assign rd_null   = (lk_rdata >= LW'(SLOTS));
	assign rd_idx    = lk_rdata[IW-1:0];
	assign rd_match  = (lk_rdata == LW'(s_q));
	assign walk_more = !rd_null && (step_q != SW'(SLOTS));
	assign list_end  = rd_null || (step_q == SW'(LIST_LIMIT));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (request.operation)
						OP_ALLOC: if (!free_null) state_d = S_ALLOC_WB;
						OP_FREE:  if (slot_ok) state_d = S_FREE_HEAD;
						OP_LIST:  if (!head_null) state_d = S_LIST_WALK;
						OP_CLEAR: state_d = S_IDLE;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_ALLOC_WB: state_d = S_IDLE;
			S_FREE_HEAD: begin
				state_d = (head_is_s || head_null) ? S_FREE_PUSH : S_FREE_WALK;
			end
			S_FREE_WALK: begin
				if (rd_match || !walk_more) begin
					state_d = S_FREE_PUSH;
				end
			end
			S_FREE_PUSH: state_d = S_IDLE;
			S_LIST_WALK: if (list_end) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		lk_ctl    = '0;
		lk_raddr  = '0;
		lk_waddr  = '0;
		lk_wdata  = '0;
		emit      = 1'b0;
		emit_st   = ST_OK;
		emit_slot = '0;
		emit_last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (request.operation)
						OP_ALLOC: begin
							if (free_null) begin
								emit    = 1'b1;
								emit_st = ST_POOL_EMPTY;
							end else begin
								lk_ctl.rd = 1'b1;
								lk_raddr  = free_head_q[IW-1:0];
							end
						end
						OP_FREE: begin
							if (!slot_ok) begin
								emit    = 1'b1;
								emit_st = ST_NOT_ACTIVE;
							end else begin
								lk_ctl.rd = 1'b1;
								lk_raddr  = slot_idx;
							end
						end
						OP_LIST: begin
							if (head_null) begin
								emit    = 1'b1;
								emit_st = ST_LIST_EMPTY;
							end else begin
								lk_ctl.rd = 1'b1;
								lk_raddr  = active_head_q[IW-1:0];
							end
						end
						OP_CLEAR: begin
							lk_ctl.clear = 1'b1;
							emit         = 1'b1;
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			S_ALLOC_WB: begin
				lk_ctl.wr = 1'b1;
				lk_waddr  = free_head_q[IW-1:0];
				lk_wdata  = active_head_q;
				emit      = 1'b1;
				emit_slot = free_head_q[IW-1:0];
			end
			S_FREE_HEAD: begin
				if (!head_is_s && !head_null) begin
					lk_ctl.rd = 1'b1;
					lk_raddr  = active_head_q[IW-1:0];
				end
			end
			S_FREE_WALK: begin
				if (rd_match) begin
					lk_ctl.wr = 1'b1;
					lk_waddr  = cur_q;
					lk_wdata  = nxs_q;
				end else if (walk_more) begin
					lk_ctl.rd = 1'b1;
					lk_raddr  = rd_idx;
				end
			end
			S_FREE_PUSH: begin
				lk_ctl.wr = 1'b1;
				lk_waddr  = s_q;
				lk_wdata  = free_head_q;
				emit      = 1'b1;
				emit_slot = s_q;
			end
			S_LIST_WALK: begin
				emit      = 1'b1;
				emit_slot = cur_q;
				emit_last = list_end;
				if (!list_end) begin
					lk_ctl.rd = 1'b1;
					lk_raddr  = rd_idx;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign emit_w = {4'b0000, emit_slot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			free_head_q   <= '0;
			active_head_q <= LW'(SLOTS);
			flags_q       <= '0;
			strobe_q      <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			unique case (state_q)
				S_IDLE: begin
					if (accept && request.operation == OP_CLEAR) begin
						free_head_q   <= '0;
						active_head_q <= LW'(SLOTS);
						flags_q       <= '0;
					end
				end
				S_ALLOC_WB: begin
					free_head_q                   <= lk_rdata;
					active_head_q                 <= free_head_q;
					flags_q[free_head_q[IW-1:0]] <= 1'b1;
				end
				S_FREE_HEAD: begin
					if (head_is_s) begin
						active_head_q <= lk_rdata;
					end
				end
				S_FREE_PUSH: begin
					free_head_q  <= LW'(s_q);
					flags_q[s_q] <= 1'b0;
				end
				default: begin
					flags_q <= flags_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.status   <= emit_st;
			result_q.slot_out <= emit_w[3:0];
			result_q.last     <= emit_last;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					s_q    <= slot_idx;
					cur_q  <= active_head_q[IW-1:0];
					step_q <= SW'(1);
				end
			end
			S_FREE_HEAD: begin
				nxs_q  <= lk_rdata;
				cur_q  <= active_head_q[IW-1:0];
				step_q <= SW'(1);
			end
			S_FREE_WALK, S_LIST_WALK: begin
				cur_q  <= rd_idx;
				step_q <= step_q + SW'(1);
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

`default_nettype wire

FILE: rtl/spa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/spa_links.sv
// Next-link store: a RAM of links plus one valid bit per entry, so that an
// entry never written since reset or clear reads as its reset link (index + 1).
// Depends on spa_pkg and spa_ram.
`timescale 1ns / 1ps
`default_nettype none

module spa_links
	import spa_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire link_ctl_t                  ctl,
	input  wire logic [$clog2(SLOTS)-1:0]   raddr,
	input  wire logic [$clog2(SLOTS)-1:0]   waddr,
	input  wire logic [$clog2(SLOTS+1)-1:0] wdata,
	output logic      [$clog2(SLOTS+1)-1:0] rdata
);

	localparam int IW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);

	logic [SLOTS-1:0] valid_q;
	logic [IW-1:0]    raddr_s1;
	logic             rvalid_s1;
	logic [LW-1:0]    ram_rdata;

	spa_ram #(
		.WIDTH(LW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ctl.wr),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ctl.rd),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
		end else if (ctl.wr) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			raddr_s1  <= raddr;
			rvalid_s1 <= valid_q[raddr];
		end
	end

	assign rdata = rvalid_s1 ? ram_rdata : LW'(raddr_s1) + LW'(1);

endmodule

`default_nettype wire

FILE: rtl/spa_checker.sv
// Port-level checker for the slot pool allocator, attached by bind.
// Depends on spa_pkg and on slot_pool_free_list_allocator.
`timescale 1ns / 1ps
`default_nettype none

module spa_checker
	import spa_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire request_t request,
	input wire logic     busy,
	input wire result_t  result,
	input wire logic     strobe
);

	// A result that is not the last of its request leaves the block busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("more results pending but block is idle");

	// Every error result carries slot zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != ST_OK |-> result.slot_out == 4'd0)
		else $error("error result with nonzero slot");

	// An error result is always the only result of its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != ST_OK |-> result.last)
		else $error("error result not marked last");

	// Clear answers in the next cycle with a single ok result.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.operation == OP_CLEAR |=>
			strobe && result.last && result.status == ST_OK && !busy)
		else $error("clear did not answer at once");

endmodule

bind slot_pool_free_list_allocator spa_checker u_spa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.request(request),
	.busy   (busy),
	.result (result),
	.strobe (strobe)
);

`default_nettype wire

FILE: tb/slot_pool_free_list_allocator_tb.sv
// Self-checking testbench for the slot pool allocator: directed and random
// requests, with a shadow of the free stack and active list to check each result.
// Depends on spa_pkg and the slot_pool_free_list_allocator RTL.
`timescale 1ns / 1ps

module slot_pool_free_list_allocator_tb;

	import spa_pkg::*;

	localparam int SLOTS       = SLOTS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_REQS = 305;

	class pool_tracker;
		logic [4:0]       link [SLOTS];
		logic [4:0]       act_head;
		logic [4:0]       free_top;
		logic [SLOTS-1:0] in_use;
		result_t          slot_outcomes [$];
		int               errors;
		int               checked;
		int               empties;
		int               rejects;
		int               longest;

		function new();
			errors  = 0;
			checked = 0;
			empties = 0;
			rejects = 0;
			longest = 0;
			reset_pool();
		endfunction

		function void reset_pool();
			for (int i = 0; i < SLOTS; i++)
				link[i] = 5'(i + 1);
			act_head = 5'(SLOTS);
			free_top = 5'd0;
			in_use   = '0;
		endfunction

		function void push_outcome(status_t st, logic [3:0] s, logic lst);
			result_t r;
			r.status   = st;
			r.slot_out = s;
			r.last     = lst;
			slot_outcomes.push_back(r);
		endfunction

		function void take_request(request_t req);
			logic [4:0] cur;
			logic [4:0] nxt;
			logic [4:0] target;
			logic       found;
			int         k;
			target = {1'b0, req.slot};
			case (req.operation)
				OP_ALLOC: begin
					if (free_top >= SLOTS) begin
						empties++;
						push_outcome(ST_POOL_EMPTY, 4'd0, 1'b1);
					end else begin
						cur      = free_top;
						free_top = link[cur];
						link[cur] = act_head;
						act_head = cur;
						in_use[cur] = 1'b1;
						push_outcome(ST_OK, cur[3:0], 1'b1);
					end
				end
				OP_FREE: begin
					if (!in_use[req.slot]) begin
						rejects++;
						push_outcome(ST_NOT_ACTIVE, 4'd0, 1'b1);
					end else begin
						if (act_head == target) begin
							act_head = link[target];
						end else begin
							cur   = act_head;
							found = 1'b0;
							for (int n = 0; n < SLOTS && cur < SLOTS && !found; n++) begin
								if (link[cur] == target) begin
									link[cur] = link[target];
									found = 1'b1;
								end else begin
									cur = link[cur];
								end
							end
						end
						link[target] = free_top;
						free_top = target;
						in_use[req.slot] = 1'b0;
						push_outcome(ST_OK, req.slot, 1'b1);
					end
				end
				OP_LIST: begin
					if (act_head >= SLOTS) begin
						push_outcome(ST_LIST_EMPTY, 4'd0, 1'b1);
					end else begin
						cur = act_head;
						k   = 0;
						while (k < SLOTS && k < MAX_RESULTS && cur < SLOTS) begin
							nxt = link[cur];
							push_outcome(ST_OK, cur[3:0], nxt >= SLOTS || k + 1 >= MAX_RESULTS
								|| k + 1 >= SLOTS);
							cur = nxt;
							k++;
						end
						if (k > longest)
							longest = k;
					end
				end
				default: begin
					reset_pool();
					push_outcome(ST_OK, 4'd0, 1'b1);
				end
			endcase
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (slot_outcomes.size() == 0) begin
				$error("unexpected result: status %0d slot_out %0d last %0d",
					got.status, got.slot_out, got.last);
				errors++;
				return;
			end
			want = slot_outcomes.pop_front();
			checked++;
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.slot_out !== want.slot_out) begin
				$error("slot_out: expected %0d, got %0d", want.slot_out, got.slot_out);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction

		function logic [3:0] pick_active();
			logic [3:0] s;
			s = 4'($urandom);
			if (in_use != '0) begin
				while (!in_use[s])
					s = 4'($urandom);
			end
			return s;
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	request_t request;
	logic     busy;
	result_t  result;
	logic     strobe;

	pool_tracker pool;
	int          cycles;
	int          idle_pct;
	int          alloc_pct;
	int          op_count [4];

	slot_pool_free_list_allocator #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.result (result),
		.strobe (strobe)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			pool.match_result(result);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("slot_pool_free_list_allocator_tb: FAIL");
			$finish;
		end
	end

	task automatic send_request(op_t op, logic [3:0] s);
		request_t req;
		req.operation = op;
		req.slot      = s;
		start   <= 1'b1;
		request <= req;
		do
			@(posedge clk);
		while (busy);
		pool.take_request(req);
		op_count[op]++;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	task automatic random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < alloc_pct)
			send_request(OP_ALLOC, 4'($urandom));
		else if (r < 80)
			send_request(OP_FREE, pool.pick_active());
		else if (r < 88)
			send_request(OP_FREE, 4'($urandom));
		else if (r < 98)
			send_request(OP_LIST, 4'($urandom));
		else
			send_request(OP_CLEAR, 4'($urandom));
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		start     = 1'b0;
		request   = '0;
		cycles    = 0;
		idle_pct  = 21;
		alloc_pct = 50;
		op_count  = '{default: 0};
		pool      = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_request(OP_LIST, 4'd0);
		send_request(OP_FREE, 4'd15);
		for (int i = 0; i < SLOTS; i++)
			send_request(OP_ALLOC, 4'(i));
		send_request(OP_ALLOC, 4'd15);
		send_request(OP_LIST, 4'd0);
		send_request(OP_FREE, 4'd15);
		send_request(OP_FREE, 4'd0);
		send_request(OP_FREE, 4'd7);
		send_request(OP_FREE, 4'd7);
		send_request(OP_LIST, 4'd15);
		send_request(OP_CLEAR, 4'd15);
		send_request(OP_LIST, 4'd0);
		send_request(OP_ALLOC, 4'd0);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n == RANDOM_REQS / 3)
				idle_pct = 61;
			else if (n == 2 * RANDOM_REQS / 3)
				idle_pct = 0;
			if (n % 40 == 0)
				alloc_pct = (n / 40) % 2 == 0 ? 62 : 22;
			random_request();
		end
		start <= 1'b0;

		while (pool.slot_outcomes.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);

		$display("Covered %0d allocate, %0d free, %0d list and %0d clear requests; %0d results checked.",
			op_count[OP_ALLOC], op_count[OP_FREE], op_count[OP_LIST], op_count[OP_CLEAR],
			pool.checked);
		$display("Pool-empty allocations %0d, rejected frees %0d, longest listing %0d slots.",
			pool.empties, pool.rejects, pool.longest);
		if (pool.errors == 0 && pool.slot_outcomes.size() == 0)
			$display("slot_pool_free_list_allocator_tb: PASS");
		else
			$display("slot_pool_free_list_allocator_tb: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/spa_pkg.sv
rtl/spa_ram.sv
rtl/spa_links.sv
rtl/slot_pool_free_list_allocator.sv
rtl/spa_checker.sv
tb/slot_pool_free_list_allocator_tb.sv
